>>> hw/rtl/density_layer_stratifier_assert.svh
// Assertion macros shared by the density layer stratifier RTL.
`ifndef DENSITY_LAYER_STRATIFIER_ASSERT_SVH
`define DENSITY_LAYER_STRATIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dls check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dls check failed");

`endif

>>> hw/rtl/dls_pkg.sv
// Types and constants shared by the density layer stratifier modules.
`default_nettype none

package dls_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int LAYER_W        = 10;
  localparam int COUNT_OUT_W    = 11;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;
  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [0:0] {
    AR_SQR = 1'b0,
    AR_DIV = 1'b1
  } ar_op_t;

  typedef struct packed {
    logic   start;
    ar_op_t op;
  } ar_req_t;

  typedef struct packed {
    logic                 cmd;
    logic [31:0]          score;
    logic [31:0]          sorted_key;
    logic [LAYER_W-1:0]   point_at_rank;
    logic                 last_item;
    logic [LAYER_W-1:0]   query_point;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [LAYER_W-1:0]     layer_value;
    logic [COUNT_OUT_W-1:0] point_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/dls_arith.sv
// Shared iterative unit: shift-add squaring and restoring division.
`default_nettype none

`include "density_layer_stratifier_assert.svh"

module dls_arith #(
  parameter int VALUE_BITS = dls_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dls_pkg::ar_req_t     req,
  input  wire logic [((2*VALUE_BITS-16 > 64) ? 64 : 2*VALUE_BITS-16)+CNT_W-1:0] opnd,
  input  wire logic [CNT_W-1:0]     dvsr,
  output logic                      done,
  output logic [((2*VALUE_BITS-16 > 64) ? 64 : 2*VALUE_BITS-16)+CNT_W-1:0] res
);

  localparam int VB  = VALUE_BITS;
  localparam int PW  = 2 * VB;
  localparam int TW  = (PW - 16 > 64) ? 64 : PW - 16;
  localparam int AW  = TW + CNT_W;
  localparam int WW  = (PW > AW) ? PW : AW;
  localparam int ITW = $clog2(((AW > VB) ? AW : VB) + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  dls_pkg::ar_op_t     op_r, op_nxt;
  logic [ITW-1:0]      cnt_r, cnt_nxt;
  logic [WW-1:0]       work_r, work_nxt;
  logic [VB-1:0]       mcand_r, mcand_nxt;
  logic [CNT_W-1:0]    dvsr_r, dvsr_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;

  logic [VB:0]         sq_sum;
  logic [CNT_W:0]      rsh;
  logic                ge;
  logic [PW-17:0]      sh;
  logic                ovf;
  logic [TW-1:0]       term;

  always_comb begin
    sq_sum = {1'b0, work_r[PW-1:VB]} + (work_r[0] ? {1'b0, mcand_r} : '0);
    rsh    = {rem_r, work_r[AW-1]};
    ge     = (rsh >= {1'b0, dvsr_r});
    sh     = work_r[PW-1:16];
    ovf    = ((sh >> TW) != '0);
    term   = ovf ? '1 : TW'(sh);
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    work_nxt  = work_r;
    mcand_nxt = mcand_r;
    dvsr_nxt  = dvsr_r;
    rem_nxt   = rem_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      op_nxt    = req.op;
      dvsr_nxt  = dvsr;
      rem_nxt   = '0;
      mcand_nxt = opnd[VB-1:0];
      if (req.op == dls_pkg::AR_SQR) begin
        work_nxt = WW'(opnd[VB-1:0]);
        cnt_nxt  = ITW'(VB);
      end else begin
        work_nxt = WW'(opnd);
        cnt_nxt  = ITW'(AW);
      end
    end else if (busy_r) begin
      if (op_r == dls_pkg::AR_SQR) begin
        work_nxt = WW'({sq_sum, work_r[VB-1:1]});
      end else begin
        rem_nxt  = ge ? CNT_W'(rsh - {1'b0, dvsr_r}) : CNT_W'(rsh);
        work_nxt = WW'({work_r[AW-2:0], ge});
      end
      cnt_nxt = cnt_r - ITW'(1);
      if (cnt_r == ITW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= dls_pkg::AR_SQR;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r  <= work_nxt;
    mcand_r <= mcand_nxt;
    dvsr_r  <= dvsr_nxt;
    rem_r   <= rem_nxt;
  end

  assign done = done_r;
  assign res  = (op_r == dls_pkg::AR_DIV) ? work_r[AW-1:0] : AW'(term);

  `DLS_ASSERT_NOW(a_start_idle, req.start, !busy_r)
  `DLS_ASSERT_NEXT(a_done_pulse, done_r, !done_r)
  `DLS_ASSERT_NOW(a_busy_count, busy_r, cnt_r != '0)

endmodule

`default_nettype wire

>>> hw/rtl/density_layer_stratifier.sv
// Top level of the density layer stratifier: stores, sequencer and result port.
//
// Usage: items are offered on in_item with start; a transfer happens at a rising
// edge where start is high and busy is low. A load (cmd 0) writes the score,
// sorted key and rank at the next load position. A load with last_item set
// closes the batch and starts a run; when the run ends, one done result (noise
// layer and point count) is shown on out_item with out_strobe. A query (cmd 1)
// keeps busy high while it is answered, and its answer is strobed in the same
// cycle that busy falls again.
// A run clears the layer store, sums the scores, accumulates the variance and
// then, per layer pass, walks the stores and makes up to two divisions, all on
// the one shared unit.
// After reset the block is busy while the layer store is cleared. Results are
// strobed for exactly one cycle; the receiver takes each one as it comes.
`default_nettype none

`include "density_layer_stratifier_assert.svh"

module density_layer_stratifier #(
  parameter int MAX_POINTS = dls_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = dls_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire dls_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output dls_pkg::out_item_t      out_item
);

  localparam int VB = VALUE_BITS;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int TW = (2 * VB - 16 > 64) ? 64 : 2 * VB - 16;
  localparam int AW = TW + CW;
  localparam int LW = dls_pkg::LAYER_W;

  typedef enum logic [21:0] {
    S_CLR     = 22'd1,
    S_IDLE    = 22'd2,
    S_QRY     = 22'd4,
    S_SUM_RD  = 22'd8,
    S_SUM_AC  = 22'd16,
    S_MEAN_W  = 22'd32,
    S_VAR_RD  = 22'd64,
    S_VAR_SQ  = 22'd128,
    S_VAR_W   = 22'd256,
    S_VAR_DW  = 22'd512,
    S_PASS    = 22'd1024,
    S_KS_RD   = 22'd2048,
    S_KS_AC   = 22'd4096,
    S_KS_DW   = 22'd8192,
    S_ADV_RD  = 22'd16384,
    S_ADV_CMP = 22'd32768,
    S_ASG_RR  = 22'd65536,
    S_ASG_SR  = 22'd131072,
    S_ASG_AC  = 22'd262144,
    S_SM_DW   = 22'd524288,
    S_RS_RR   = 22'd1048576,
    S_RS_WR   = 22'd2097152
  } state_t;

  // Stores.
  logic [VB-1:0] score_mem [MAX_POINTS];
  logic [VB-1:0] key_mem   [MAX_POINTS];
  logic [LW-1:0] rank_mem  [MAX_POINTS];
  logic [LW-1:0] layer_mem [MAX_POINTS];

  logic [VB-1:0] score_q, key_q;
  logic [LW-1:0] rank_q, layer_q;

  logic          load_we;
  logic [IW-1:0] load_wa;
  logic [IW-1:0] score_ra, key_ra, rank_ra, layer_ra;
  logic          layer_we;
  logic [IW-1:0] layer_wa;
  logic [LW-1:0] layer_wd;

  state_t             state_r, state_nxt;
  logic               run_r, run_nxt;
  logic               closed_r, closed_nxt;
  logic               q_ok_r, q_ok_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cut_r, cut_nxt;
  logic [CW-1:0]      nc_r, nc_nxt;
  logic [CW-1:0]      layer_r, layer_nxt;
  logic [AW-1:0]      acc_r, acc_nxt;
  logic [VB-1:0]      mean_r, mean_nxt;
  logic [VB-1:0]      thr_r, thr_nxt;
  logic [VB-1:0]      kmean_r, kmean_nxt;
  dls_pkg::ar_req_t   ar_req_r, ar_req_nxt;
  logic [AW-1:0]      ar_opnd_r, ar_opnd_nxt;
  logic [CW-1:0]      ar_dvsr_r, ar_dvsr_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  dls_pkg::out_item_t out_item_r, out_item_nxt;

  logic               ar_done;
  logic [AW-1:0]      ar_res;

  logic               accept;
  logic [CW-1:0]      idx_inc;
  logic [VB-1:0]      abs_diff;
  logic [VB-1:0]      var_sat;
  logic [VB:0]        thr_sum;
  logic               rank_ok;

  dls_arith #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CW)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req_r),
    .opnd  (ar_opnd_r),
    .dvsr  (ar_dvsr_r),
    .done  (ar_done),
    .res   (ar_res)
  );

  always_comb begin
    accept   = start && (state_r == S_IDLE);
    idx_inc  = idx_r + CW'(1);
    abs_diff = (score_q >= mean_r) ? (score_q - mean_r) : (mean_r - score_q);
    var_sat  = ((ar_res >> VB) != '0) ? '1 : VB'(ar_res);
    thr_sum  = {1'b0, mean_r} + {1'b0, var_sat};
    rank_ok  = (32'(rank_q) < 32'(count_r));
  end

  always_comb begin
    state_nxt      = state_r;
    run_nxt        = run_r;
    closed_nxt     = closed_r;
    q_ok_nxt       = q_ok_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cut_nxt        = cut_r;
    nc_nxt         = nc_r;
    layer_nxt      = layer_r;
    acc_nxt        = acc_r;
    mean_nxt       = mean_r;
    thr_nxt        = thr_r;
    kmean_nxt      = kmean_r;
    ar_req_nxt     = '{start: 1'b0, op: ar_req_r.op};
    ar_opnd_nxt    = ar_opnd_r;
    ar_dvsr_nxt    = ar_dvsr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    load_we        = 1'b0;
    load_wa        = IW'(count_r);
    score_ra       = IW'(idx_r);
    key_ra         = IW'(idx_r);
    rank_ra        = IW'(idx_r);
    layer_ra       = IW'(in_item.query_point);
    layer_we       = 1'b0;
    layer_wa       = IW'(idx_r);
    layer_wd       = LW'(layer_r);

    unique case (state_r)
      S_CLR: begin
        layer_we = 1'b1;
        layer_wd = '0;
        idx_nxt  = idx_inc;
        if (idx_r == CW'(MAX_POINTS - 1)) begin
          idx_nxt = '0;
          acc_nxt = '0;
          run_nxt = 1'b0;
          state_nxt = run_r ? S_SUM_RD : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_item.cmd == dls_pkg::CMD_LOAD) begin
            if (closed_r) begin
              load_we    = 1'b1;
              load_wa    = '0;
              count_nxt  = CW'(1);
              closed_nxt = 1'b0;
            end else if (count_r < CW'(MAX_POINTS)) begin
              load_we   = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            if (in_item.last_item) begin
              run_nxt   = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_CLR;
            end
          end else begin
            q_ok_nxt  = (32'(in_item.query_point) < 32'(MAX_POINTS));
            state_nxt = S_QRY;
          end
        end
      end
      S_QRY: begin
        out_strobe_nxt           = 1'b1;
        out_item_nxt.result_kind = dls_pkg::KIND_QUERY;
        out_item_nxt.layer_value = q_ok_r ? layer_q : '0;
        out_item_nxt.point_count = dls_pkg::COUNT_OUT_W'(count_r);
        state_nxt                = S_IDLE;
      end
      S_SUM_RD: state_nxt = S_SUM_AC;
      S_SUM_AC: begin
        acc_nxt = acc_r + AW'(score_q);
        idx_nxt = idx_inc;
        if (idx_inc == count_r) begin
          ar_req_nxt  = '{start: 1'b1, op: dls_pkg::AR_DIV};
          ar_opnd_nxt = acc_r + AW'(score_q);
          ar_dvsr_nxt = count_r;
          state_nxt   = S_MEAN_W;
        end else begin
          state_nxt = S_SUM_RD;
        end
      end
      S_MEAN_W: begin
        if (ar_done) begin
          mean_nxt  = VB'(ar_res);
          idx_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_VAR_RD;
        end
      end
      S_VAR_RD: state_nxt = S_VAR_SQ;
      S_VAR_SQ: begin
        ar_req_nxt  = '{start: 1'b1, op: dls_pkg::AR_SQR};
        ar_opnd_nxt = AW'(abs_diff);
        state_nxt   = S_VAR_W;
      end
      S_VAR_W: begin
        if (ar_done) begin
          acc_nxt = acc_r + ar_res;
          idx_nxt = idx_inc;
          if (idx_inc == count_r) begin
            ar_req_nxt  = '{start: 1'b1, op: dls_pkg::AR_DIV};
            ar_opnd_nxt = acc_r + ar_res;
            ar_dvsr_nxt = count_r;
            state_nxt   = S_VAR_DW;
          end else begin
            state_nxt = S_VAR_RD;
          end
        end
      end
      S_VAR_DW: begin
        if (ar_done) begin
          thr_nxt   = thr_sum[VB] ? '1 : thr_sum[VB-1:0];
          cut_nxt   = '0;
          layer_nxt = '0;
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        if (({1'b0, cut_r} + (CW+1)'(1)) < {1'b0, count_r}) begin
          idx_nxt   = cut_r;
          acc_nxt   = '0;
          state_nxt = S_KS_RD;
        end else begin
          out_strobe_nxt           = 1'b1;
          out_item_nxt.result_kind = dls_pkg::KIND_DONE;
          out_item_nxt.layer_value = (layer_r == '0) ? '0 : LW'(layer_r - CW'(1));
          out_item_nxt.point_count = dls_pkg::COUNT_OUT_W'(count_r);
          closed_nxt               = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_KS_RD: state_nxt = S_KS_AC;
      S_KS_AC: begin
        acc_nxt = acc_r + AW'(key_q);
        idx_nxt = idx_inc;
        if (idx_inc == count_r) begin
          ar_req_nxt  = '{start: 1'b1, op: dls_pkg::AR_DIV};
          ar_opnd_nxt = acc_r + AW'(key_q);
          ar_dvsr_nxt = count_r - cut_r;
          state_nxt   = S_KS_DW;
        end else begin
          state_nxt = S_KS_RD;
        end
      end
      S_KS_DW: begin
        if (ar_done) begin
          kmean_nxt = VB'(ar_res);
          nc_nxt    = cut_r;
          state_nxt = S_ADV_RD;
        end
      end
      S_ADV_RD: begin
        key_ra = IW'(nc_r);
        if (nc_r == count_r) begin
          idx_nxt   = cut_r;
          acc_nxt   = '0;
          state_nxt = S_ASG_RR;
        end else begin
          state_nxt = S_ADV_CMP;
        end
      end
      S_ADV_CMP: begin
        if (key_q < kmean_r) begin
          nc_nxt    = nc_r + CW'(1);
          state_nxt = S_ADV_RD;
        end else begin
          idx_nxt   = cut_r;
          acc_nxt   = '0;
          state_nxt = S_ASG_RR;
        end
      end
      S_ASG_RR: begin
        if (idx_r == nc_r) begin
          if (nc_r == cut_r) begin
            // Nothing passed: this is the last layer.
            idx_nxt   = nc_r;
            state_nxt = S_RS_RR;
          end else begin
            ar_req_nxt  = '{start: 1'b1, op: dls_pkg::AR_DIV};
            ar_opnd_nxt = acc_r;
            ar_dvsr_nxt = nc_r - cut_r;
            state_nxt   = S_SM_DW;
          end
        end else begin
          state_nxt = S_ASG_SR;
        end
      end
      S_ASG_SR: begin
        score_ra = IW'(rank_q);
        layer_wa = IW'(rank_q);
        if (rank_ok) begin
          layer_we  = 1'b1;
          state_nxt = S_ASG_AC;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_ASG_RR;
        end
      end
      S_ASG_AC: begin
        acc_nxt   = acc_r + AW'(score_q);
        idx_nxt   = idx_inc;
        state_nxt = S_ASG_RR;
      end
      S_SM_DW: begin
        if (ar_done) begin
          if (ar_res >= AW'(thr_r)) begin
            idx_nxt   = nc_r;
            state_nxt = S_RS_RR;
          end else begin
            cut_nxt   = nc_r;
            layer_nxt = layer_r + CW'(1);
            state_nxt = S_PASS;
          end
        end
      end
      S_RS_RR: begin
        if (idx_r == count_r) begin
          cut_nxt   = count_r;
          layer_nxt = layer_r + CW'(1);
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_RS_WR;
        end
      end
      S_RS_WR: begin
        layer_wa  = IW'(rank_q);
        layer_we  = rank_ok;
        idx_nxt   = idx_inc;
        state_nxt = S_RS_RR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      score_mem[load_wa] <= VB'(in_item.score);
      key_mem[load_wa]   <= VB'(in_item.sorted_key);
      rank_mem[load_wa]  <= in_item.point_at_rank;
    end
    score_q <= score_mem[score_ra];
    key_q   <= key_mem[key_ra];
    rank_q  <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (layer_we) begin
      layer_mem[layer_wa] <= layer_wd;
    end
    layer_q <= layer_mem[layer_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      run_r        <= 1'b0;
      closed_r     <= 1'b0;
      count_r      <= '0;
      idx_r        <= '0;
      ar_req_r     <= '{start: 1'b0, op: dls_pkg::AR_SQR};
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_r        <= run_nxt;
      closed_r     <= closed_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      ar_req_r     <= ar_req_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    q_ok_r     <= q_ok_nxt;
    cut_r      <= cut_nxt;
    nc_r       <= nc_nxt;
    layer_r    <= layer_nxt;
    acc_r      <= acc_nxt;
    mean_r     <= mean_nxt;
    thr_r      <= thr_nxt;
    kmean_r    <= kmean_nxt;
    ar_opnd_r  <= ar_opnd_nxt;
    ar_dvsr_r  <= ar_dvsr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `DLS_ASSERT_NEXT(a_out_gap, out_strobe_r, !out_strobe_r)
  `DLS_ASSERT_NOW(a_out_idle, out_strobe_r, state_r == S_IDLE)
  `DLS_ASSERT_NOW(a_adv_range, state_r == S_ADV_RD, (nc_r >= cut_r) && (nc_r <= count_r))

endmodule

`default_nettype wire

>>> dv/tb_density_layer_stratifier.sv
// Self-checking testbench for the density layer stratifier: loads, runs and queries.
`timescale 1ns / 100ps
`default_nettype none

module tb_density_layer_stratifier;

  localparam int NPTS        = dls_pkg::MAX_POINTS_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [63:0] VAL_MAX = 64'hFFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  dls_pkg::in_item_t  in_item = '0;
  logic               out_strobe;
  dls_pkg::out_item_t out_item;

  density_layer_stratifier dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's state.
  logic [31:0] score_mem [NPTS];
  logic [31:0] key_mem   [NPTS];
  logic [9:0]  rank_mem  [NPTS];
  logic [9:0]  layer_mem [NPTS];
  int unsigned pts_loaded = 0;
  logic [9:0]  done_layer = '0;
  bit          batch_done = 1'b0;

  dls_pkg::out_item_t pending_results [$];
  int          errors = 0;
  int          items_sent = 0;
  int          runs_sent = 0;
  int          queries_sent = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  function automatic logic [63:0] sq_term(logic [63:0] d);
    logic [127:0] p;
    p = (128'(d) * 128'(d)) >> 16;
    return (p > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] rank_score(int pos, int n);
    return (rank_mem[pos] < n) ? 64'(score_mem[rank_mem[pos]]) : 64'd0;
  endfunction

  function automatic void mark_layer(int pos, int n, int lay);
    if (rank_mem[pos] < n) layer_mem[rank_mem[pos]] = 10'(lay);
  endfunction

  function automatic void stratify();
    int n, cut, lay, nc;
    logic [127:0] acc, ka, sa;
    logic [63:0]  mean, var_s, thr, kmean, smean;
    bit           last;
    n = pts_loaded;
    cut = 0;
    lay = 0;
    for (int i = 0; i < NPTS; i++) layer_mem[i] = '0;
    if (n == 0) begin
      done_layer = '0;
      return;
    end
    acc = '0;
    for (int i = 0; i < n; i++) acc += 128'(score_mem[i]);
    mean = 64'(acc / n);
    acc = '0;
    for (int i = 0; i < n; i++)
      acc += 128'(sq_term((64'(score_mem[i]) >= mean) ? 64'(score_mem[i]) - mean
                                                       : mean - 64'(score_mem[i])));
    var_s = 64'(acc / n);
    if (var_s > VAL_MAX) var_s = VAL_MAX;
    thr = mean + var_s;
    if (thr < mean || thr > VAL_MAX) thr = VAL_MAX;
    while (cut + 1 < n) begin
      ka = '0;
      sa = '0;
      nc = cut;
      for (int i = cut; i < n; i++) ka += 128'(key_mem[i]);
      kmean = 64'(ka / (n - cut));
      while (nc < n && 64'(key_mem[nc]) < kmean) nc++;
      for (int i = cut; i < nc; i++) begin
        sa += 128'(rank_score(i, n));
        mark_layer(i, n, lay);
      end
      if (nc == cut) begin
        last = 1'b1;
      end else begin
        smean = 64'(sa / (nc - cut));
        last = (smean >= thr);
      end
      if (last) begin
        for (int i = nc; i < n; i++) mark_layer(i, n, lay);
        cut = n;
      end else begin
        cut = nc;
      end
      lay++;
    end
    done_layer = 10'((lay == 0) ? 0 : lay - 1);
  endfunction

  // Updates the shadow state for one accepted item and queues the result of a query or of a batch's last load.
  function automatic void predict_item(dls_pkg::in_item_t it);
    dls_pkg::out_item_t r;
    if (it.cmd == dls_pkg::CMD_LOAD) begin
      if (batch_done) begin
        pts_loaded = 0;
        batch_done = 1'b0;
      end
      if (pts_loaded < NPTS) begin
        score_mem[pts_loaded] = it.score;
        key_mem[pts_loaded]   = it.sorted_key;
        rank_mem[pts_loaded]  = it.point_at_rank;
        pts_loaded++;
      end
      if (!it.last_item) return;
      stratify();
      batch_done = 1'b1;
      r.result_kind = dls_pkg::KIND_DONE;
      r.layer_value = done_layer;
    end else begin
      r.result_kind = dls_pkg::KIND_QUERY;
      r.layer_value = layer_mem[it.query_point];
    end
    r.point_count = dls_pkg::COUNT_OUT_W'(pts_loaded);
    pending_results = {pending_results, r};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    dls_pkg::out_item_t w;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", out_item.result_kind, -1);
      end else begin
        w = pending_results.pop_front();
        if (out_item.result_kind !== w.result_kind)
          report_mismatch("result_kind", out_item.result_kind, w.result_kind);
        if (out_item.layer_value !== w.layer_value)
          report_mismatch("layer_value", out_item.layer_value, w.layer_value);
        if (out_item.point_count !== w.point_count)
          report_mismatch("point_count", out_item.point_count, w.point_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one item and returns once its transfer has happened.
  task automatic send_item(dls_pkg::in_item_t it);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_item(it);
    items_sent++;
    if (it.cmd == dls_pkg::CMD_LOAD && it.last_item) runs_sent++;
    if (it.cmd == dls_pkg::CMD_QUERY) queries_sent++;
  endtask

  task automatic load_point(logic [31:0] sc, logic [31:0] key, logic [9:0] rk, bit last);
    dls_pkg::in_item_t it;
    it = '0;
    it.cmd = dls_pkg::CMD_LOAD;
    it.score = sc;
    it.sorted_key = key;
    it.point_at_rank = rk;
    it.last_item = last;
    it.query_point = 10'($urandom);
    send_item(it);
  endtask

  // Query with random content in the fields the block ignores.
  task automatic query_point(logic [9:0] p);
    dls_pkg::in_item_t it;
    it = dls_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = dls_pkg::CMD_QUERY;
    it.query_point = p;
    send_item(it);
  endtask

  task automatic query_range(int n);
    for (int i = 0; i < n; i++) query_point(10'(i));
  endtask

  task automatic test_single_point();
    load_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0, 1'b1);
    query_point(10'd0);
    query_point(10'd1023);
  endtask

  task automatic test_extreme_scores();
    load_point(32'h0, 32'h0, 10'd2, 1'b0);
    load_point(32'hFFFF_FFFF, 32'h1_0000, 10'd0, 1'b0);
    load_point(32'h0, 32'h8000_0000, 10'd1, 1'b0);
    load_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd3, 1'b1);
    query_range(4);
  endtask

  // Equal keys leave nothing below the mean, so the first pass is the last.
  task automatic test_empty_advance();
    for (int i = 0; i < 4; i++)
      load_point(32'(i) << 16, 32'h0003_0000, 10'(3 - i), i == 3);
    query_range(4);
  endtask

  // Ranks past the batch add nothing, and a lone trailing point stays at layer 0.
  task automatic test_bad_rank_and_leftover();
    load_point(32'h0001_0000, 32'h0000_0001, 10'd1023, 1'b0);
    load_point(32'h0002_0000, 32'h0000_0002, 10'd0, 1'b0);
    load_point(32'h0000_0100, 32'h0010_0000, 10'd2, 1'b1);
    query_range(3);
  endtask

  task automatic random_batch();
    int          n;
    int          perm [];
    logic [31:0] key, sc_base, sc;
    int          smode, tmp, j;
    bit          broken;
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    perm = new[n];
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    broken = ($urandom_range(9) == 0);
    smode = $urandom_range(3);
    sc_base = $urandom;
    key = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 32'h10_0000));
    for (int i = 0; i < n; i++) begin
      case (smode)
        0: sc = 32'($urandom_range(0, 32'h4_0000));
        1: sc = $urandom;
        2: sc = sc_base;
        default: sc = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 255));
      endcase
      if (broken) key = $urandom;
      load_point(sc, key, ($urandom_range(19) == 0) ? 10'($urandom) : 10'(perm[i]),
                 i == n - 1);
      if (key < 32'hF000_0000)
        key += ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(1, 32'h8_0000));
    end
    for (int i = 0; i < $urandom_range(1, n + 2); i++)
      query_point(($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(0, n + 1)));
  endtask

  task automatic test_random();
    int b;
    b = 0;
    while (items_sent < 430) begin
      steady = (b >= 10 && b < 16);
      random_batch();
      b++;
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NPTS; i++) layer_mem[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_point();
    test_extreme_scores();
    test_empty_advance();
    test_bad_rank_and_leftover();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d items: %0d stratification runs and %0d layer queries",
             items_sent, runs_sent, queries_sent);
    $display("%0d mismatches seen", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/dls_pkg.sv
hw/rtl/dls_arith.sv
hw/rtl/density_layer_stratifier.sv
dv/tb_density_layer_stratifier.sv
